// ----- design/stepper_step_dir_generator_top_defines.svh -----
// Assertion macros for the step/dir generator checker.
// No dependencies; included by the checker file only.
`ifndef STEPPER_STEP_DIR_GENERATOR_TOP_DEFINES_SVH
`define STEPPER_STEP_DIR_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SSDG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SSDG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ssdg_pkg.sv -----
// Shared constants for the step/dir generator: widths, defaults, register indexes.
// No dependencies.
package ssdg_pkg;

	localparam int SPEED_WIDTH     = 32;
	localparam int CFG_DATA_WIDTH  = 16;
	localparam int CFG_INDEX_WIDTH = 8;

	localparam int POS_WIDTH_DEF   = 48;
	localparam int PICK_BIT_DEF    = 32;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam logic [CFG_DATA_WIDTH-1:0] CFG_RESET_VALUE = CFG_DATA_WIDTH'(1);

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PULSE_HIGH = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PULSE_LOW  = CFG_INDEX_WIDTH'(1);
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DIR_SETUP  = CFG_INDEX_WIDTH'(2);
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DIR_HOLD   = CFG_INDEX_WIDTH'(3);

endpackage

// ----- design/stepper_step_dir_generator_top.sv -----
// Step/dir pulse generator for one stepper axis (DDA phase accumulator).
// A tick's word is registered at its accepting edge, into the skid word while the output stalls.
// Throughput: one tick per cycle while the skid word is empty; the update is one add plus counts.
// Output register plus a one-word skid stage, so one more input word is taken on a stall.
// Reset (arst_n low, async): state cleared, dir-hold phase, timing registers = 1.
// Depends on ssdg_pkg.
module stepper_step_dir_generator_top #(
	parameter int POS_WIDTH   = ssdg_pkg::POS_WIDTH_DEF,
	parameter int PICK_BIT    = ssdg_pkg::PICK_BIT_DEF,
	parameter int COUNT_WIDTH = ssdg_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write_en,
	input  logic [ssdg_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [ssdg_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [ssdg_pkg::SPEED_WIDTH-1:0] speed,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  step_level,
	output logic                                  dir_level,
	output logic signed [POS_WIDTH-1:0]           accum_position
);
	import ssdg_pkg::*;

	typedef enum logic [4:0] {
		PH_DIR_HOLD  = 5'b00001,
		PH_DIR_SETUP = 5'b00010,
		PH_STEP_WAIT = 5'b00100,
		PH_STEP_HIGH = 5'b01000,
		PH_STEP_LOW  = 5'b10000
	} phase_t;

	// pickoff mask is zero when the pickoff bit lies above the accumulator
	localparam logic [POS_WIDTH-1:0] PICK_MASK = POS_WIDTH'(64'd1 << PICK_BIT);
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	// timing registers
	logic [CFG_DATA_WIDTH-1:0] pulse_high_q, pulse_low_q, dir_setup_q, dir_hold_q;

	// axis state (dir pin and last direction always agree, so one bit)
	phase_t                  phase_q, phase_d;
	logic [POS_WIDTH-1:0]    acc_q, acc_d;
	logic [POS_WIDTH-1:0]    last_pos_q, last_pos_d;
	logic [COUNT_WIDTH-1:0]  pulse_cnt_q, pulse_cnt_d;
	logic [COUNT_WIDTH-1:0]  dir_cnt_q, dir_cnt_d;
	logic                    dir_q, dir_d;
	logic                    step_q, step_d;

	// output register and skid word
	logic                    out_valid_q, skid_valid_q;
	logic                    out_step_q, out_dir_q, skid_step_q, skid_dir_q;
	logic [POS_WIDTH-1:0]    out_acc_q, skid_acc_q;

	logic                    in_fire;
	logic                    negative, positive, reversal;
	logic [63:0]             speed_ext;

	assign in_ready = !skid_valid_q;
	assign in_fire  = in_valid && in_ready;

	assign negative  = speed[SPEED_WIDTH-1];
	assign positive  = (speed != '0) && !negative;
	assign speed_ext = 64'(speed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_high_q <= CFG_RESET_VALUE;
			pulse_low_q  <= CFG_RESET_VALUE;
			dir_setup_q  <= CFG_RESET_VALUE;
			dir_hold_q   <= CFG_RESET_VALUE;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_PULSE_HIGH: pulse_high_q <= cfg_data;
				CFG_PULSE_LOW:  pulse_low_q  <= cfg_data;
				CFG_DIR_SETUP:  dir_setup_q  <= cfg_data;
				CFG_DIR_HOLD:   dir_hold_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// one tick, phases in fixed order so zero-length times fall through
	always_comb begin
		phase_d     = phase_q;
		acc_d       = acc_q;
		last_pos_d  = last_pos_q;
		pulse_cnt_d = pulse_cnt_q;
		dir_cnt_d   = dir_cnt_q;
		dir_d       = dir_q;
		step_d      = step_q;
		reversal    = 1'b0;

		if (pulse_cnt_d != '0) pulse_cnt_d = pulse_cnt_d - CNT_ONE;
		if (dir_cnt_d != '0) dir_cnt_d = dir_cnt_d - CNT_ONE;

		if (phase_d != PH_DIR_HOLD) begin
			acc_d = acc_q + POS_WIDTH'(speed_ext);
		end else if (dir_cnt_d == '0) begin
			dir_d     = !negative;
			phase_d   = PH_DIR_SETUP;
			dir_cnt_d = COUNT_WIDTH'(dir_setup_q);
		end

		if (phase_d == PH_DIR_SETUP && dir_cnt_d == '0) phase_d = PH_STEP_WAIT;

		if (phase_d == PH_STEP_WAIT && ((acc_d ^ last_pos_q) & PICK_MASK) != '0) begin
			step_d      = 1'b1;
			last_pos_d  = acc_d;
			phase_d     = PH_STEP_HIGH;
			pulse_cnt_d = COUNT_WIDTH'(pulse_high_q);
		end

		if (phase_d == PH_STEP_HIGH && pulse_cnt_d == '0) begin
			step_d      = 1'b0;
			phase_d     = PH_STEP_LOW;
			pulse_cnt_d = COUNT_WIDTH'(pulse_low_q);
			dir_cnt_d   = COUNT_WIDTH'(dir_hold_q);
		end

		if (phase_d == PH_STEP_LOW && pulse_cnt_d == '0) begin
			// zero speed never reverses
			reversal = dir_d ? negative : positive;
			phase_d  = reversal ? PH_DIR_HOLD : PH_STEP_WAIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DIR_HOLD;
			acc_q       <= '0;
			last_pos_q  <= '0;
			pulse_cnt_q <= '0;
			dir_cnt_q   <= '0;
			dir_q       <= 1'b0;
			step_q      <= 1'b0;
		end else if (in_fire) begin
			phase_q     <= phase_d;
			acc_q       <= acc_d;
			last_pos_q  <= last_pos_d;
			pulse_cnt_q <= pulse_cnt_d;
			dir_cnt_q   <= dir_cnt_d;
			dir_q       <= dir_d;
			step_q      <= step_d;
		end
	end

	// output word control; skid holds a word accepted while the output stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q  <= skid_valid_q || in_fire;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_step_q <= skid_step_q;
				out_dir_q  <= skid_dir_q;
				out_acc_q  <= skid_acc_q;
			end else if (in_fire) begin
				out_step_q <= step_d;
				out_dir_q  <= dir_d;
				out_acc_q  <= acc_d;
			end
		end else if (in_fire) begin
			skid_step_q <= step_d;
			skid_dir_q  <= dir_d;
			skid_acc_q  <= acc_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign step_level     = out_step_q;
	assign dir_level      = out_dir_q;
	assign accum_position = out_acc_q;

endmodule

// ----- design/ssdg_checker.sv -----
// Port-level checks for the step/dir generator output buffering.
// Depends on ssdg_pkg and stepper_step_dir_generator_top_defines.svh; bound to the top level.
`include "stepper_step_dir_generator_top_defines.svh"

module ssdg_checker #(
	parameter int POS_WIDTH = ssdg_pkg::POS_WIDTH_DEF
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic signed [ssdg_pkg::SPEED_WIDTH-1:0] speed,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic                                   step_level,
	input logic                                   dir_level,
	input logic signed [POS_WIDTH-1:0]            accum_position
);
	import ssdg_pkg::*;

	// a stalled word keeps its payload
	`SSDG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(step_level) && $stable(dir_level) && $stable(accum_position), "stalled output word changed")

	// input only backs up once the output register is full
	`SSDG_ASSERT_IMP(a_ready_full, clk, arst_n, !in_ready, out_valid, "input stalled with empty output")

	// word taken during an output stall parks in the skid stage
	`SSDG_ASSERT_NEXT(a_skid_fill, clk, arst_n, out_valid && !out_ready && in_valid && in_ready, !in_ready && out_valid, "skid word not held")

	// draining the output moves the skid word forward
	`SSDG_ASSERT_NEXT(a_skid_drain, clk, arst_n, out_valid && out_ready && !in_ready, out_valid && in_ready, "skid word lost on drain")

endmodule

bind stepper_step_dir_generator_top ssdg_checker #(.POS_WIDTH(POS_WIDTH)) u_ssdg_checker (.*);

// ----- dv/tb_stepper_step_dir_generator_top.sv -----
`timescale 1ns / 1ps
// Testbench for stepper_step_dir_generator_top: a directed table, then random speed runs.
// A behavioral axis model predicts every word the table does not give. Depends on ssdg_pkg and the DUT.
module tb_stepper_step_dir_generator_top;
	import ssdg_pkg::*;

	localparam int POS_W = POS_WIDTH_DEF;
	localparam int PICK  = PICK_BIT_DEF;
	localparam int CNT_W = COUNT_WIDTH_DEF;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_LO = CFG_INDEX_WIDTH'(4);
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_HI = '1;

	typedef enum logic [2:0] {
		AX_DIR_HOLD, AX_DIR_SETUP, AX_STEP_WAIT, AX_STEP_HIGH, AX_STEP_LOW
	} axis_phase_t;

	typedef struct packed {
		logic             step_lvl;
		logic             dir_lvl;
		logic [POS_W-1:0] pos;
	} pin_word_t;

	typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		logic [CFG_INDEX_WIDTH-1:0] index;
		logic [31:0]                value;
		bit                         typed;
		pin_word_t                  want;
	} plan_row_t;

	localparam pin_word_t NO_WORD = '0;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_write_en;
	logic [CFG_INDEX_WIDTH-1:0]    cfg_index;
	logic [CFG_DATA_WIDTH-1:0]     cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [SPEED_WIDTH-1:0] speed;
	logic                          out_valid;
	logic                          out_ready;
	logic                          step_level;
	logic                          dir_level;
	logic signed [POS_W-1:0]       accum_position;

	stepper_step_dir_generator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.speed         (speed),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.step_level    (step_level),
		.dir_level     (dir_level),
		.accum_position(accum_position)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// axis model state
	logic [CNT_W-1:0] high_ticks, low_ticks, setup_ticks, hold_ticks;
	logic [POS_W-1:0] acc, last_step_pos;
	logic [CNT_W-1:0] pulse_cnt, dir_cnt;
	axis_phase_t      ax_phase;
	logic             last_dir, step_out, dir_pin;

	pin_word_t expected_words[$];
	int n_errors = 0;
	int n_ticks = 0;
	int n_words = 0;
	int n_pulses = 0;
	int n_dir_flips = 0;
	int n_settings = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int run_left = 0;
	bit run_positive = 1'b0;

	// directed table: reset defaults first, then all timing registers at zero and unused indexes written
	plan_row_t plan [26] = '{
		'{ROW_TICK, '0, 32'h0000_0000, 1'b1, {1'b0, 1'b1, 48'h0000_0000_0000}},
		'{ROW_TICK, '0, 32'h7FFF_FFFF, 1'b1, {1'b0, 1'b1, 48'h0000_7FFF_FFFF}},
		'{ROW_TICK, '0, 32'h7FFF_FFFF, 1'b1, {1'b0, 1'b1, 48'h0000_FFFF_FFFE}},
		'{ROW_TICK, '0, 32'h0000_0002, 1'b1, {1'b1, 1'b1, 48'h0001_0000_0000}},
		'{ROW_TICK, '0, 32'h8000_0000, 1'b1, {1'b0, 1'b1, 48'h0000_8000_0000}},
		'{ROW_TICK, '0, 32'hFFFF_FFFF, 1'b1, {1'b0, 1'b1, 48'h0000_7FFF_FFFF}},
		'{ROW_TICK, '0, 32'hFFFF_FFFF, 1'b1, {1'b0, 1'b0, 48'h0000_7FFF_FFFF}},
		'{ROW_TICK, '0, 32'h8000_0000, 1'b0, NO_WORD},
		'{ROW_TICK, '0, 32'h0000_0000, 1'b0, NO_WORD},
		'{ROW_TICK, '0, 32'h7FFF_FFFF, 1'b0, NO_WORD},
		'{ROW_REG, CFG_PULSE_HIGH, 32'h0000, 1'b0, NO_WORD},
		'{ROW_REG, CFG_PULSE_LOW,  32'h0000, 1'b0, NO_WORD},
		'{ROW_REG, CFG_DIR_SETUP,  32'h0000, 1'b0, NO_WORD},
		'{ROW_REG, CFG_DIR_HOLD,   32'h0000, 1'b0, NO_WORD},
		'{ROW_REG, CFG_UNUSED_LO,  32'h0007, 1'b0, NO_WORD},
		'{ROW_REG, CFG_UNUSED_HI,  32'hFFFF, 1'b0, NO_WORD},
		'{ROW_TICK, '0, 32'h8000_0000, 1'b0, NO_WORD},
		'{ROW_TICK, '0, 32'h8000_0000, 1'b0, NO_WORD},
		'{ROW_TICK, '0, 32'h8000_0000, 1'b0, NO_WORD},
		'{ROW_TICK, '0, 32'h0000_0000, 1'b0, NO_WORD},
		'{ROW_TICK, '0, 32'h0000_0000, 1'b0, NO_WORD},
		'{ROW_TICK, '0, 32'h7FFF_FFFF, 1'b0, NO_WORD},
		'{ROW_TICK, '0, 32'h7FFF_FFFF, 1'b0, NO_WORD},
		'{ROW_TICK, '0, 32'h7FFF_FFFF, 1'b0, NO_WORD},
		'{ROW_TICK, '0, 32'hFFFF_FFFF, 1'b0, NO_WORD},
		'{ROW_TICK, '0, 32'h0000_0001, 1'b0, NO_WORD}
	};

	task automatic clear_axis_model();
		high_ticks    = CFG_RESET_VALUE;
		low_ticks     = CFG_RESET_VALUE;
		setup_ticks   = CFG_RESET_VALUE;
		hold_ticks    = CFG_RESET_VALUE;
		acc           = '0;
		last_step_pos = '0;
		pulse_cnt     = '0;
		dir_cnt       = '0;
		ax_phase      = AX_DIR_HOLD;
		last_dir      = 1'b0;
		step_out      = 1'b0;
		dir_pin       = 1'b0;
	endtask

	// one tick of the axis; the stages fall through in order, so zero times chain
	function automatic pin_word_t advance_axis(input logic [31:0] v);
		logic             neg, pos, rev;
		logic [POS_W-1:0] ext;
		pin_word_t        w;
		neg = v[31];
		pos = (v != '0) && !neg;
		ext = {{(POS_W-32){v[31]}}, v};
		if (pulse_cnt != '0) pulse_cnt = pulse_cnt - 1'b1;
		if (dir_cnt != '0) dir_cnt = dir_cnt - 1'b1;
		if (ax_phase != AX_DIR_HOLD) begin
			acc = acc + ext;
		end else if (dir_cnt == '0) begin
			if (dir_pin != !neg) n_dir_flips++;
			dir_pin  = !neg;
			last_dir = !neg;
			ax_phase = AX_DIR_SETUP;
			dir_cnt  = setup_ticks;
		end
		if (ax_phase == AX_DIR_SETUP && dir_cnt == '0) ax_phase = AX_STEP_WAIT;
		if (ax_phase == AX_STEP_WAIT && acc[PICK] != last_step_pos[PICK]) begin
			step_out      = 1'b1;
			last_step_pos = acc;
			ax_phase      = AX_STEP_HIGH;
			pulse_cnt     = high_ticks;
			n_pulses++;
		end
		if (ax_phase == AX_STEP_HIGH && pulse_cnt == '0) begin
			step_out  = 1'b0;
			ax_phase  = AX_STEP_LOW;
			pulse_cnt = low_ticks;
			dir_cnt   = hold_ticks;
		end
		if (ax_phase == AX_STEP_LOW && pulse_cnt == '0) begin
			// zero speed is never a reversal
			rev      = last_dir ? neg : pos;
			ax_phase = rev ? AX_DIR_HOLD : AX_STEP_WAIT;
		end
		w.step_lvl = step_out;
		w.dir_lvl  = dir_pin;
		w.pos      = acc;
		return w;
	endfunction

	// mostly same-sign runs of large speeds so steps come often; some noise mixed in
	function automatic logic [31:0] next_speed();
		int          mode;
		logic [31:0] mag;
		if (run_left == 0) begin
			run_positive = !run_positive;
			run_left     = int'($urandom_range(4, 40));
		end
		run_left--;
		mode = int'($urandom_range(0, 19));
		mag  = $urandom_range(32'h1000_0000, 32'h7FFF_FFFF);
		if (mode == 0) return $urandom();
		if (mode == 1) return '0;
		if (mode == 2) return 32'(int'($urandom_range(0, 255)) - 128);
		if (run_positive) return mag;
		if (mode == 3) return 32'h8000_0000;
		return -mag;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("ERROR word %0d %s: got %h, expected %h", n_words, what, got, want);
		n_errors++;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
		input logic [CFG_DATA_WIDTH-1:0] val);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
		@(posedge clk);
		case (idx)
			CFG_PULSE_HIGH: high_ticks = val;
			CFG_PULSE_LOW:  low_ticks = val;
			CFG_DIR_SETUP:  setup_ticks = val;
			CFG_DIR_HOLD:   hold_ticks = val;
			default: ;
		endcase
	endtask

	task automatic wait_drain();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic send_tick(input logic [31:0] v, input bit typed, input pin_word_t want);
		pin_word_t model_word;
		if ($urandom_range(1, 100) <= gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		speed    <= v;
		do @(posedge clk); while (!in_ready);
		model_word = advance_axis(v);
		expected_words.push_back(typed ? want : model_word);
		n_ticks++;
	endtask

	task automatic start_phase(input logic [CNT_W-1:0] h, input logic [CNT_W-1:0] l,
		input logic [CNT_W-1:0] s, input logic [CNT_W-1:0] d);
		in_valid <= 1'b0;
		wait_drain();
		write_reg(CFG_PULSE_HIGH, h);
		write_reg(CFG_PULSE_LOW, l);
		write_reg(CFG_DIR_SETUP, s);
		write_reg(CFG_DIR_HOLD, d);
		cfg_write_en <= 1'b0;
		n_settings++;
	endtask

	// receiver: stalls out_ready in random bursts
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && $urandom_range(1, 100) <= stall_pct)
				stall_left = int'($urandom_range(1, 7));
			out_ready <= (stall_left == 0);
			if (stall_left != 0) stall_left--;
		end
	end

	always @(posedge clk) begin
		pin_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("word with nothing expected",
					64'({step_level, dir_level, accum_position}), 64'd0);
			end else begin
				want = expected_words.pop_front();
				if (step_level !== want.step_lvl)
					report_mismatch("step_level", 64'(step_level), 64'(want.step_lvl));
				if (dir_level !== want.dir_lvl)
					report_mismatch("dir_level", 64'(dir_level), 64'(want.dir_lvl));
				if (accum_position !== want.pos)
					report_mismatch("accum_position", 64'($unsigned(accum_position)),
						64'(want.pos));
			end
			n_words++;
		end
	end

	initial begin
		int gap_by_phase [6];
		int stall_by_phase [6];
		int cfg_top [6];
		bit writing;
		gap_by_phase   = '{15, 40, 0, 25, 5, 0};
		stall_by_phase = '{5, 2, 12, 0, 8, 0};
		cfg_top        = '{2, 4, 1, 12, 3, 6};
		writing = 1'b0;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		speed        <= '0;
		cfg_write_en <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		clear_axis_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct    = 20;
		stall_pct  = 6;
		n_settings = 2;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				if (!writing) begin
					in_valid <= 1'b0;
					wait_drain();
					writing = 1'b1;
				end
				write_reg(plan[i].index, plan[i].value[CFG_DATA_WIDTH-1:0]);
			end else begin
				if (writing) begin
					cfg_write_en <= 1'b0;
					writing = 1'b0;
				end
				send_tick(plan[i].value, plan[i].typed, plan[i].want);
			end
		end

		for (int ph = 0; ph < 6; ph++) begin
			start_phase(CNT_W'($urandom_range(0, cfg_top[ph])),
				CNT_W'($urandom_range(0, cfg_top[ph])),
				CNT_W'($urandom_range(0, cfg_top[ph])),
				CNT_W'($urandom_range(0, cfg_top[ph])));
			gap_pct   = gap_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			for (int k = 0; k < 200; k++) begin
				// hold off mid-run until the pipe is empty
				if (ph == 2 && k == 100) begin
					in_valid <= 1'b0;
					wait_drain();
				end
				send_tick(next_speed(), 1'b0, NO_WORD);
			end
		end

		// widest timing; only the first loaded counter gets to run here
		start_phase('1, '1, '1, '1);
		for (int k = 0; k < 120; k++) send_tick(next_speed(), 1'b0, NO_WORD);

		in_valid <= 1'b0;
		wait_drain();
		repeat (4) @(posedge clk);
		$display("Sent %0d ticks under %0d timing settings, checked %0d words.",
			n_ticks, n_settings, n_words);
		$display("Model saw %0d step pulses and %0d direction changes.",
			n_pulses, n_dir_flips);
		if (n_errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d words still expected", expected_words.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
